FILE: design/md5_message_digest_unit_defines.svh
// Assertion macros for the MD5 digest unit
`ifndef MD5_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MD5_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MD5_ASSERT(lbl, clk, rst_n, prop, msg)
`define MD5_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

FILE: design/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;

  // buffer write source select
  typedef enum logic [1:0] {
    WSEL_DATA = 2'd0,
    WSEL_PAD  = 2'd1,
    WSEL_ZERO = 2'd2,
    WSEL_LEN  = 2'd3
  } wsel_e;

  typedef struct packed {
    logic       buf_we;
    wsel_e      wsel;
    logic       cnt_inc;
    logic       ld_rnd;    // copy chaining words into working regs
    logic       rnd_en;    // run one step
    logic       fold;      // add working regs into chaining words
    logic       restart;
    logic       len_snap;  // capture bit count as length
    logic       dig_ld;    // load output register
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] pos;       // fill position of the buffer
  } md5_sts_t;

  function automatic logic [31:0] step_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by step i
  function automatic logic [3:0] word_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

FILE: design/md5_if.sv
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;
  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;
  modport source (output valid, digest_low, digest_high, input ready);
  modport sink (input valid, digest_low, digest_high, output ready);
endinterface

FILE: design/md5_datapath.sv
module md5_datapath
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  md5_cmd_t    cmd_i,
  input  logic [5:0]  step_i,
  input  logic [7:0]  data_i,
  output md5_sts_t    sts_o,
  output logic [63:0] dig_low_o,
  output logic [63:0] dig_high_o
);

  // 16 words, one write port (byte lanes), one read port
  logic [31:0] mem_q [16];
  logic [63:0] cnt_q, len_q;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] w_q;
  logic [63:0] dl_q, dh_q;
  logic [7:0]  wbyte;
  logic [5:0]  pos;
  logic [31:0] f, sum, rot;
  logic [5:0]  rd_step;

  assign pos = cnt_q[8:3];
  assign sts_o.pos = pos;

  always_comb begin
    case (cmd_i.wsel)
      WSEL_DATA: wbyte = data_i;
      WSEL_PAD:  wbyte = PAD_BYTE;
      WSEL_ZERO: wbyte = '0;
      WSEL_LEN:  wbyte = len_q[{pos[2:0], 3'b000} +: 8];
      default:   wbyte = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      mem_q[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wbyte;
    end
  end

  // word for the next step is registered while the current step runs
  assign rd_step = cmd_i.ld_rnd ? 6'd0 : 6'(step_i + 6'd1);
  always_ff @(posedge clk_i) begin
    w_q <= mem_q[word_g(rd_step)];
  end

  always_comb begin
    case (step_i[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + f + step_k(step_i) + w_q;
    rot = (sum << rot_s(step_i)) | (sum >> (6'd32 - {1'b0, rot_s(step_i)}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      h_q[0] <= IV0;
      h_q[1] <= IV1;
      h_q[2] <= IV2;
      h_q[3] <= IV3;
    end else begin
      if (cmd_i.restart) begin
        cnt_q <= '0;
        h_q[0] <= IV0;
        h_q[1] <= IV1;
        h_q[2] <= IV2;
        h_q[3] <= IV3;
      end else begin
        if (cmd_i.cnt_inc) cnt_q <= cnt_q + 64'd8;
        else if (cmd_i.buf_we) cnt_q <= {cnt_q[63:9], pos + 6'd1, 3'b000};
        if (cmd_i.fold) begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_snap) len_q <= cnt_q;
    if (cmd_i.ld_rnd) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
    end else if (cmd_i.rnd_en) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
    if (cmd_i.dig_ld) begin
      dl_q <= {h_q[1], h_q[0]};
      dh_q <= {h_q[3], h_q[2]};
    end
  end

  assign dig_low_o  = dl_q;
  assign dig_high_o = dh_q;

endmodule

FILE: design/md5_ctrl.sv
module md5_ctrl
  import md5_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       byte_present_i,
  input  logic       last_byte_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  md5_sts_t   sts_i,
  output md5_cmd_t   cmd_o,
  output logic [5:0] step_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RUN, S_FOLD, S_PAD, S_FILL, S_EMIT
  } state_e;

  state_e     state_q;
  logic [5:0] step_q;
  logic       fin_q;   // finishing a message
  logic       lenp_q;  // length already written for this compression
  logic       padp_q;  // pad byte still to be written
  logic       zonly_q; // pad left no room for the length in this block
  logic       ov_q;
  logic       acc;

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign step_o      = step_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.wsel = WSEL_DATA;
    case (state_q)
      S_IDLE: if (acc && byte_present_i) begin
        cmd_o.buf_we = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end else if (acc && last_byte_i) cmd_o.len_snap = 1'b1;
      S_LOAD: cmd_o.ld_rnd = 1'b1;
      S_RUN:  cmd_o.rnd_en = 1'b1;
      S_FOLD: cmd_o.fold = 1'b1;
      S_PAD: begin
        cmd_o.buf_we = 1'b1;
        cmd_o.wsel = WSEL_PAD;
        cmd_o.len_snap = 1'b1;
      end
      S_FILL: begin
        cmd_o.buf_we = 1'b1;
        cmd_o.wsel = (!lenp_q && !zonly_q && sts_i.pos >= 6'd56) ? WSEL_LEN : WSEL_ZERO;
      end
      S_EMIT: begin
        cmd_o.dig_ld = 1'b1;
        cmd_o.restart = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      fin_q <= 1'b0;
      lenp_q <= 1'b0;
      padp_q <= 1'b0;
      zonly_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (acc) begin
          fin_q <= last_byte_i;
          lenp_q <= 1'b0;
          padp_q <= last_byte_i;
          if (byte_present_i && sts_i.pos == 6'd63) state_q <= S_LOAD;
          else if (last_byte_i) state_q <= S_PAD;
        end
        S_LOAD: begin
          step_q <= '0;
          zonly_q <= 1'b0;
          state_q <= S_RUN;
        end
        S_RUN: begin
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) state_q <= S_FOLD;
        end
        S_FOLD: begin
          if (!fin_q) state_q <= S_IDLE;
          else if (lenp_q) state_q <= S_EMIT;
          else if (padp_q) state_q <= S_PAD;
          else state_q <= S_FILL;
        end
        S_PAD: begin
          padp_q <= 1'b0;
          zonly_q <= (sts_i.pos >= 6'd56);
          state_q <= (sts_i.pos == 6'd63) ? S_LOAD : S_FILL;
        end
        S_FILL: begin
          if (!lenp_q && !zonly_q && sts_i.pos >= 6'd56) begin
            if (sts_i.pos == 6'd63) begin
              lenp_q <= 1'b1;
              state_q <= S_LOAD;
            end
          end else if (sts_i.pos == 6'd63) state_q <= S_LOAD;
        end
        S_EMIT: begin
          ov_q <= 1'b1;
          fin_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/md5_message_digest_unit.sv
// MD5 digest unit, one message byte per transaction.
// A byte that does not fill the block is simply stored; a full block adds
// the load, the 64-step compression loop (one step a cycle) and the fold.
// Finish: pad/zero/length written one byte a cycle, plus one or two
// compressions, then the digest is registered. Async active-low reset
// restores the initial chaining words and clears the bit count.
`include "md5_message_digest_unit_defines.svh"
module md5_message_digest_unit
  import md5_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  md5_in_if.sink    in_if,
  md5_out_if.source out_if
);

  md5_cmd_t   cmd;
  md5_sts_t   sts;
  logic [5:0] step;

  md5_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i     (in_if.valid),
    .byte_present_i (in_if.byte_present),
    .last_byte_i    (in_if.last_byte),
    .in_ready_o     (in_if.ready),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .step_o         (step)
  );

  md5_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .step_i     (step),
    .data_i     (in_if.data_byte),
    .sts_o      (sts),
    .dig_low_o  (out_if.digest_low),
    .dig_high_o (out_if.digest_high)
  );

  `MD5_ASSERT(a_no_ready_when_out, clk_i, rst_ni, out_if.valid |-> !in_if.ready, "ready while result pending")
  `MD5_ASSERT(a_fold_after_run, clk_i, rst_ni, cmd.fold |-> $past(cmd.rnd_en), "fold without steps")
  `MD5_ASSERT(a_one_action, clk_i, rst_ni, $onehot0({cmd.ld_rnd, cmd.rnd_en, cmd.fold, cmd.buf_we}), "conflicting commands")

endmodule

FILE: test/md5_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side view of the two channels; the design's interfaces are used directly.
// This file only keeps the helper record types shared by the top module.
package md5_tb_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } digest_t;
endpackage

FILE: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic clk_i;
  logic rst_ni;

  md5_in_if  in_if ();
  md5_out_if out_if ();

  md5_message_digest_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // predictor state
  logic [31:0] chain_q [4];
  logic [7:0]  blk_q [64];
  logic [63:0] nbits_q;

  digest_t digest_q [$];
  int      mismatch_cnt;
  int      send_idle_pct;
  int      recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("md5_message_digest_unit test failed");
    $finish;
  end

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic int step_shift(input int i);
    int tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return tab[((i >> 4) << 2) | (i & 3)];
  endfunction

  function automatic logic [31:0] step_add(input int i);
    logic [31:0] tab [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return tab[i];
  endfunction

  task automatic fold_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i+3], blk_q[4*i+2], blk_q[4*i+1], blk_q[4*i]};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      case (i >> 4)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) & 15; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) & 15; end
        default: begin f = c ^ (b | ~d); g = (7 * i) & 15; end
      endcase
      t = d; d = c; c = b;
      b = b + rol32(a + f + step_add(i) + w[g], step_shift(i));
      a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endtask

  task automatic restart_chain();
    chain_q = '{IV0, IV1, IV2, IV3};
    nbits_q = '0;
  endtask

  // update the predictor with one accepted transaction
  task automatic hash_item(input byte_item_t it);
    int pos;
    logic [63:0] len;
    digest_t dg;
    if (it.byte_present) begin
      pos = int'(nbits_q[8:3]);
      blk_q[pos] = it.data_byte;
      nbits_q += 64'd8;
      if (pos == 63) fold_block();
    end
    if (it.last_byte) begin
      len = nbits_q;
      pos = int'(nbits_q[8:3]);
      blk_q[pos] = PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) blk_q[pos++] = 8'h00;
        fold_block();
        pos = 0;
      end
      while (pos < 56) blk_q[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) blk_q[56 + i] = len[8*i +: 8];
      fold_block();
      dg.digest_low  = {chain_q[1], chain_q[0]};
      dg.digest_high = {chain_q[3], chain_q[2]};
      digest_q.push_back(dg);
      restart_chain();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // valid stays high after the accepting edge until the next falling edge
  task automatic send_item(input byte_item_t it);
    @(negedge clk_i);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.data_byte    <= it.data_byte;
    in_if.byte_present <= it.byte_present;
    in_if.last_byte    <= it.last_byte;
    do @(posedge clk_i); while (!in_if.ready);
    hash_item(it);
  endtask

  task automatic send_message(input int nbytes, input bit fill);
    byte_item_t it;
    for (int i = 0; i < nbytes; i++) begin
      it.data_byte    = fill ? 8'($urandom) : 8'hFF;
      it.byte_present = 1'b1;
      it.last_byte    = (i == nbytes - 1);
      send_item(it);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // receiver and checker
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest with no expectation", $realtime);
        mismatch_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (out_if.digest_low !== want.digest_low)
          report_mismatch("digest_low", out_if.digest_low, want.digest_low);
        if (out_if.digest_high !== want.digest_high)
          report_mismatch("digest_high", out_if.digest_high, want.digest_high);
      end
    end
  end

  task automatic test_directed();
    byte_item_t it;
    // empty message right after reset
    it = '{data_byte: 8'h00, byte_present: 1'b0, last_byte: 1'b1};
    send_item(it);
    // no byte, no mark: ignored
    it = '{data_byte: 8'hA5, byte_present: 1'b0, last_byte: 1'b0};
    send_item(it);
    // single extreme bytes with the last mark
    it = '{data_byte: 8'h00, byte_present: 1'b1, last_byte: 1'b1};
    send_item(it);
    it = '{data_byte: 8'hFF, byte_present: 1'b1, last_byte: 1'b1};
    send_item(it);
    // byte then a bare last mark
    it = '{data_byte: 8'h5A, byte_present: 1'b1, last_byte: 1'b0};
    send_item(it);
    it = '{data_byte: 8'h00, byte_present: 1'b0, last_byte: 1'b1};
    send_item(it);
    drain();
  endtask

  // padding boundaries: one or two final compressions, full blocks
  task automatic test_boundaries();
    int lens [8] = '{55, 56, 57, 63, 64, 65, 119, 128};
    foreach (lens[i]) send_message(lens[i], 1'b1);
    drain();
  endtask

  task automatic test_random(input int budget);
    byte_item_t it;
    int sent, n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) begin
        // noise: bare items including ignored ones
        it.data_byte    = 8'($urandom);
        it.byte_present = 1'($urandom_range(1));
        it.last_byte    = 1'($urandom_range(1));
        send_item(it);
        if (it.byte_present || it.last_byte) sent++;
      end else begin
        n = ($urandom_range(7) == 0) ? $urandom_range(150) : $urandom_range(70);
        for (int i = 0; i < n; i++) begin
          it.data_byte    = 8'($urandom);
          it.byte_present = 1'b1;
          it.last_byte    = 1'b0;
          send_item(it);
        end
        it.data_byte    = 8'($urandom);
        it.byte_present = 1'($urandom_range(1));
        it.last_byte    = 1'b1;
        send_item(it);
        sent += n + 1;
      end
    end
    drain();
  endtask

  initial begin
    mismatch_cnt       = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    in_if.valid        = 1'b0;
    in_if.data_byte    = '0;
    in_if.byte_present = 1'b0;
    in_if.last_byte    = 1'b0;
    blk_q = '{default: 8'h00};
    restart_chain();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    send_idle_pct = 38; recv_idle_pct = 56;
    test_boundaries();
    test_random(360);
    send_idle_pct = 56; recv_idle_pct = 38;
    test_random(360);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(360);

    if (mismatch_cnt == 0 && digest_q.size() == 0)
      $display("md5_message_digest_unit test passed");
    else
      $display("md5_message_digest_unit test failed");
    $finish;
  end
endmodule
